// File: hdl/tlvd_pkg.sv
// shared types, constants and the crc-16 byte update for the tlv deframer
// no dependencies; used by every module of the block
package tlvd_pkg;

	// frame limits and widths
	localparam int MAX_LEN  = 64;
	localparam int LEN_W    = $clog2(MAX_LEN + 1);
	localparam int IDX_W    = $clog2(MAX_LEN);
	localparam int BANKS    = 2;
	localparam int MEM_AW   = IDX_W + $clog2(BANKS);
	localparam int MEM_DEPTH = MAX_LEN * BANKS;

	// event queue between front and back
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_SOF_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOF_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_SEED   = 2'd2;

	localparam logic [7:0]  SOF_FIRST_RST  = 8'hAA;
	localparam logic [7:0]  SOF_SECOND_RST = 8'h55;
	localparam logic [15:0] CRC_SEED_RST   = 16'hFFFF;

	// crc-16 with polynomial 0x1021, msb first
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_MSB  = 16'h8000;

	typedef enum logic [1:0] {
		ST_GOOD    = 2'd0,
		ST_BAD_LEN = 2'd1,
		ST_BAD_CRC = 2'd2
	} status_t;

	// one classified frame outcome
	typedef struct packed {
		status_t          status;
		logic [7:0]       frame_type;
		logic [LEN_W-1:0] frame_length;
		logic [15:0]      error_value;
		logic             bank;
	} evt_t;

	// payload memory write from the front
	typedef struct packed {
		logic              we;
		logic [MEM_AW-1:0] addr;
		logic [7:0]        data;
	} mem_wr_t;

	// back tells the front a payload bank is free again
	typedef struct packed {
		logic valid;
		logic bank;
	} bank_rel_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_MSB) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// File: hdl/tlvd_queue.sv
// two-entry event queue between the parsing front and the readout back
// depends on tlvd_pkg
module tlvd_queue
	import tlvd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  evt_t push_data,
	input  logic pop,
	output evt_t head,
	output logic empty,
	output logic full
);

	evt_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign head  = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// File: hdl/tlvd_front.sv
// byte parser: start-byte hunt, header, payload capture, crc check, config registers
// depends on tlvd_pkg; feeds tlvd_queue and the payload memory in tlvd_back
module tlvd_front
	import tlvd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            rx_byte,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  q_full,
	output logic                  q_push,
	output evt_t                  q_data,
	output mem_wr_t               mem_wr,
	input  bank_rel_t             bank_rel
);

	typedef enum logic [2:0] {
		PH_HUNT1,
		PH_HUNT2,
		PH_TYPE,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_DATA,
		PH_CRC_LO,
		PH_CRC_HI
	} phase_t;

	phase_t           phase_q;
	logic [7:0]       sof_first_q;
	logic [7:0]       sof_second_q;
	logic [15:0]      crc_seed_q;
	logic [7:0]       type_q;
	logic [7:0]       len_lo_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] cnt_q;
	logic [7:0]       crc_lo_q;
	logic [15:0]      crc_q;
	logic             wr_bank_q;
	logic [BANKS-1:0] bank_busy_q;

	logic        accept;
	logic [15:0] crc_in;
	logic [15:0] crc_next;
	logic [15:0] len_full;
	logic [15:0] crc_rcv;
	logic        len_bad;
	logic [LEN_W-1:0] cnt_next;
	logic [BANKS-1:0] busy_set;
	logic [BANKS-1:0] busy_clr;

	// crc runs from the seed on the type byte, then from the running value
	assign crc_in   = (phase_q == PH_TYPE) ? crc_seed_q : crc_q;
	assign crc_next = crc16_byte(crc_in, rx_byte);
	assign len_full = {rx_byte, len_lo_q};
	assign crc_rcv  = {rx_byte, crc_lo_q};
	assign len_bad  = (len_full > 16'(MAX_LEN));
	assign cnt_next = cnt_q + LEN_W'(1);

	// hold off where an event cannot be queued or the payload bank is still read out
	assign in_stall = (q_full && (phase_q == PH_LEN_HI || phase_q == PH_CRC_HI))
		|| (phase_q == PH_DATA && bank_busy_q[wr_bank_q]);
	assign accept = in_valid && !in_stall;

	// a good frame with payload claims its bank, the back frees it after readout
	assign busy_set = (accept && phase_q == PH_CRC_HI && crc_rcv == crc_q && len_q != '0)
		? (BANKS'(1) << wr_bank_q) : '0;
	assign busy_clr = bank_rel.valid ? (BANKS'(1) << bank_rel.bank) : '0;

	// payload capture into the current bank
	assign mem_wr.we   = accept && (phase_q == PH_DATA);
	assign mem_wr.addr = {wr_bank_q, cnt_q[IDX_W-1:0]};
	assign mem_wr.data = rx_byte;

	// frame outcome towards the back
	always_comb begin
		q_push = 1'b0;
		q_data = '{status: ST_GOOD, frame_type: 8'h00, frame_length: '0,
			error_value: 16'h0000, bank: wr_bank_q};
		if (accept && phase_q == PH_LEN_HI && len_bad) begin
			q_push = 1'b1;
			q_data.status      = ST_BAD_LEN;
			q_data.error_value = len_full;
		end else if (accept && phase_q == PH_CRC_HI) begin
			q_push = 1'b1;
			if (crc_rcv == crc_q) begin
				q_data.frame_type   = type_q;
				q_data.frame_length = len_q;
			end else begin
				q_data.status      = ST_BAD_CRC;
				q_data.error_value = crc_rcv;
			end
		end
	end

	// parser state, config registers and bank bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT1;
			sof_first_q  <= SOF_FIRST_RST;
			sof_second_q <= SOF_SECOND_RST;
			crc_seed_q   <= CRC_SEED_RST;
			type_q       <= 8'h00;
			len_lo_q     <= 8'h00;
			len_q        <= '0;
			cnt_q        <= '0;
			crc_lo_q     <= 8'h00;
			crc_q        <= 16'h0000;
			wr_bank_q    <= 1'b0;
			bank_busy_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SOF_FIRST:  sof_first_q  <= cfg_wdata[7:0];
					CFG_SOF_SECOND: sof_second_q <= cfg_wdata[7:0];
					CFG_CRC_SEED:   crc_seed_q   <= cfg_wdata;
					default: ;
				endcase
			end

			bank_busy_q <= (bank_busy_q & ~busy_clr) | busy_set;

			if (accept) begin
				unique case (phase_q)
					PH_HUNT1: begin
						if (rx_byte == sof_first_q) phase_q <= PH_HUNT2;
					end
					PH_HUNT2: begin
						// second start byte wins when both start bytes are equal
						if (rx_byte == sof_second_q) phase_q <= PH_TYPE;
						else if (rx_byte == sof_first_q) phase_q <= PH_HUNT2;
						else phase_q <= PH_HUNT1;
					end
					PH_TYPE: begin
						type_q  <= rx_byte;
						crc_q   <= crc_next;
						phase_q <= PH_LEN_LO;
					end
					PH_LEN_LO: begin
						len_lo_q <= rx_byte;
						crc_q    <= crc_next;
						phase_q  <= PH_LEN_HI;
					end
					PH_LEN_HI: begin
						crc_q <= crc_next;
						len_q <= len_full[LEN_W-1:0];
						cnt_q <= '0;
						if (len_bad) phase_q <= PH_HUNT1;
						else if (len_full == 16'h0000) phase_q <= PH_CRC_LO;
						else phase_q <= PH_DATA;
					end
					PH_DATA: begin
						crc_q <= crc_next;
						cnt_q <= cnt_next;
						if (cnt_next >= len_q) phase_q <= PH_CRC_LO;
					end
					PH_CRC_LO: begin
						crc_lo_q <= rx_byte;
						phase_q  <= PH_CRC_HI;
					end
					PH_CRC_HI: begin
						// a good frame with payload hands its bank to the back
						if (crc_rcv == crc_q && len_q != '0) begin
							wr_bank_q <= ~wr_bank_q;
						end
						phase_q <= PH_HUNT1;
					end
					default: phase_q <= PH_HUNT1;
				endcase
			end
		end
	end

endmodule

// File: hdl/tlvd_back.sv
// readout side: payload memory, event execution and the result output register
// depends on tlvd_pkg; takes events from tlvd_queue and writes from tlvd_front
module tlvd_back
	import tlvd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  mem_wr_t          mem_wr,
	input  evt_t             q_head,
	input  logic             q_empty,
	output logic             q_pop,
	output bank_rel_t        bank_rel,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       status,
	output logic [7:0]       frame_type,
	output logic [LEN_W-1:0] frame_length,
	output logic [IDX_W-1:0] byte_index,
	output logic [7:0]       data_byte,
	output logic             has_data,
	output logic [15:0]      error_value,
	output logic             last
);

	typedef enum logic {
		BK_IDLE,
		BK_READ
	} bk_state_t;

	logic [7:0]       mem [MEM_DEPTH];
	logic [7:0]       rd_data_q;

	bk_state_t        state_q;
	evt_t             cur_q;
	logic [IDX_W-1:0] idx_q;

	logic             can_load;
	logic             head_payload;
	logic             read_last;
	logic             rd_en;
	logic [MEM_AW-1:0] rd_addr;
	logic             load_out;

	assign can_load     = !out_valid || !out_stall;
	assign head_payload = (q_head.status == ST_GOOD) && (q_head.frame_length != '0);
	assign q_pop        = (state_q == BK_IDLE) && !q_empty && (head_payload || can_load);
	assign read_last    = ({1'b0, idx_q} + LEN_W'(1)) == cur_q.frame_length;

	// a new result enters the output register
	assign load_out = (state_q == BK_IDLE && q_pop && !head_payload)
		|| (state_q == BK_READ && can_load);

	// read of the first byte on pop, then the next byte as each one is delivered
	assign rd_en = (q_pop && head_payload)
		|| (state_q == BK_READ && can_load && !read_last);
	assign rd_addr = (state_q == BK_IDLE) ? {q_head.bank, {IDX_W{1'b0}}}
		: {cur_q.bank, idx_q + IDX_W'(1)};

	assign bank_rel.valid = (state_q == BK_READ) && can_load && read_last;
	assign bank_rel.bank  = cur_q.bank;

	// payload memory, two banks of one frame each
	always_ff @(posedge clk) begin
		if (mem_wr.we) begin
			mem[mem_wr.addr] <= mem_wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// readout sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			cur_q        <= '0;
			idx_q        <= '0;
			out_valid    <= 1'b0;
			status       <= ST_GOOD;
			frame_type   <= 8'h00;
			frame_length <= '0;
			byte_index   <= '0;
			data_byte    <= 8'h00;
			has_data     <= 1'b0;
			error_value  <= 16'h0000;
			last         <= 1'b0;
		end else begin
			// output register holds until its transfer
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				BK_IDLE: begin
					if (q_pop) begin
						if (head_payload) begin
							cur_q   <= q_head;
							idx_q   <= '0;
							state_q <= BK_READ;
						end else begin
							// error or empty frame: a single result
							status       <= q_head.status;
							frame_type   <= q_head.frame_type;
							frame_length <= '0;
							byte_index   <= '0;
							data_byte    <= 8'h00;
							has_data     <= 1'b0;
							error_value  <= q_head.error_value;
							last         <= 1'b1;
						end
					end
				end
				BK_READ: begin
					if (can_load) begin
						status       <= ST_GOOD;
						frame_type   <= cur_q.frame_type;
						frame_length <= cur_q.frame_length;
						byte_index   <= idx_q;
						data_byte    <= rd_data_q;
						has_data     <= 1'b1;
						error_value  <= 16'h0000;
						last         <= read_last;
						if (read_last) begin
							state_q <= BK_IDLE;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

endmodule

// File: hdl/tlv_frame_deframer_crc16_core.sv
// Byte-serial deframer for start-of-frame TLV frames with a CRC-16 check (poly 0x1021,
// msb first, seeded from crc_seed over type, length and payload). One byte is taken per
// cycle while in_stall is low. A good frame of N payload bytes is delivered as N results
// at one per cycle while out_stall is low, paced by the single read port of the payload
// memory; error and empty frames give one result. Two payload banks let the next frame
// be received while the previous one is read out; in_stall rises during payload bytes
// while the bank to be written is still read out, and on the last length or CRC byte when
// the two-entry event queue is full. Configuration must be written only while the block
// is idle; this is not enforced. depends on tlvd_pkg, tlvd_front, tlvd_queue, tlvd_back
module tlv_frame_deframer_crc16_core
	import tlvd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            rx_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            status,
	output logic [7:0]            frame_type,
	output logic [LEN_W-1:0]      frame_length,
	output logic [IDX_W-1:0]      byte_index,
	output logic [7:0]            data_byte,
	output logic                  has_data,
	output logic [15:0]           error_value,
	output logic                  last,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic      q_push;
	logic      q_pop;
	logic      q_full;
	logic      q_empty;
	evt_t      q_data;
	evt_t      q_head;
	mem_wr_t   mem_wr;
	bank_rel_t bank_rel;

	// parsing front
	tlvd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_data),
		.mem_wr    (mem_wr),
		.bank_rel  (bank_rel)
	);

	// event queue
	tlvd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	// readout back
	tlvd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.mem_wr       (mem_wr),
		.q_head       (q_head),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.bank_rel     (bank_rel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.frame_type   (frame_type),
		.frame_length (frame_length),
		.byte_index   (byte_index),
		.data_byte    (data_byte),
		.has_data     (has_data),
		.error_value  (error_value),
		.last         (last)
	);

	// an event is never pushed into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("event pushed into full queue");

	// nothing is popped from an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty))
		else $error("event popped from empty queue");

	// payload results belong to a good frame and stay inside its length
	a_data_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_data |->
			status == ST_GOOD && ({1'b0, byte_index} < frame_length))
		else $error("payload result outside a good frame");

	// a delivered non-final payload byte is followed by the next index of the run
	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && has_data && !last |=>
			out_valid && has_data && byte_index == $past(byte_index) + IDX_W'(1))
		else $error("payload run broken");

endmodule
